/* design/dprd_pkg.sv */
package dprd_pkg;

  localparam int unsigned InstrWidth = 32;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNSUP   = 2'd1,
    STATUS_UNALLOC = 2'd2
  } status_e;

  // major class tags, bits 28..24
  localparam logic [4:0] ClassLogical = 5'h0A;
  localparam logic [4:0] ClassAddSub  = 5'h0B;
  localparam logic [4:0] ClassMisc    = 5'h1A;
  localparam logic [4:0] ClassMul     = 5'h1B;

  // groups of the misc class, bits 23..21
  localparam logic [2:0] GrpCarry  = 3'd0;
  localparam logic [2:0] GrpCondCmp = 3'd2;
  localparam logic [2:0] GrpCondSel = 3'd4;
  localparam logic [2:0] GrpSrc    = 3'd6;

  // multiply-add op31 field, bits 23..21
  localparam logic [2:0] MulOpMadd  = 3'd0;
  localparam logic [2:0] MulOpSLong = 3'd1;
  localparam logic [2:0] MulOpSHigh = 3'd2;
  localparam logic [2:0] MulOpRsvd  = 3'd3;
  localparam logic [2:0] MulOpULong = 3'd5;
  localparam logic [2:0] MulOpUHigh = 3'd6;

  // misc class opcodes, bits 15..10
  localparam logic [5:0] OpcUdiv    = 6'd2;
  localparam logic [5:0] OpcSdiv    = 6'd3;
  localparam logic [5:0] OpcLslv    = 6'd8;
  localparam logic [5:0] OpcRorv    = 6'd11;
  localparam logic [5:0] OpcCrc32b  = 6'd16;
  localparam logic [5:0] OpcCrc32cx = 6'd23;
  localparam logic [5:0] OpcUmin    = 6'd27;
  localparam logic [5:0] OpcRev64   = 6'd3;
  localparam logic [5:0] OpcAbs     = 6'd8;

  // instruction identifier bases
  localparam logic [5:0] IdCcmpImm   = 6'd0;
  localparam logic [5:0] IdLogical   = 6'd4;
  localparam logic [5:0] IdAddSubSh  = 6'd12;
  localparam logic [5:0] IdAddSubExt = 6'd16;
  localparam logic [5:0] IdCarry     = 6'd20;
  localparam logic [5:0] IdCondSel   = 6'd24;
  localparam logic [5:0] IdDiv       = 6'd28;
  localparam logic [5:0] IdShiftV    = 6'd30;
  localparam logic [5:0] IdCrc       = 6'd34;
  localparam logic [5:0] IdOneSrc    = 6'd46;
  localparam logic [5:0] IdMsub      = 6'd55;
  localparam logic [5:0] IdMadd      = 6'd56;
  localparam logic [5:0] IdSmsubl    = 6'd57;
  localparam logic [5:0] IdSmulh     = 6'd59;
  localparam logic [5:0] IdUmsubl    = 6'd60;
  localparam logic [5:0] IdUmulh     = 6'd62;

  typedef struct packed {
    status_e    status;
    logic [5:0] instruction;
    logic [4:0] dest_reg;
    logic [4:0] first_src_reg;
    logic [4:0] second_operand;
    logic [4:0] addend_reg;
    logic       is_wide;
    logic [1:0] shift_kind;
    logic [5:0] shift_count;
    logic [2:0] extend_kind;
    logic [3:0] cond_code;
    logic [3:0] flags_value;
  } dec_result_t;

endpackage

/* design/dprd_decode.sv */
module dprd_decode import dprd_pkg::*; (
  input  logic [InstrWidth-1:0] word_i,
  output dec_result_t           result_o
);

  dec_result_t d;
  status_e     st;
  logic [2:0]  grp;
  logic [5:0]  opc;
  logic        wide;

  always_comb begin
    d    = '0;
    st   = STATUS_OK;
    grp  = word_i[23:21];
    opc  = word_i[15:10];
    wide = word_i[31];
    unique case (word_i[28:24])
      ClassLogical: begin
        d.dest_reg       = word_i[4:0];
        d.first_src_reg  = word_i[9:5];
        d.second_operand = word_i[20:16];
        d.is_wide        = wide;
        d.instruction    = IdLogical + {3'b000, word_i[30:29], word_i[21]};
        d.shift_kind     = word_i[23:22];
        d.shift_count    = word_i[15:10];
        if (!wide && word_i[15]) st = STATUS_UNALLOC;
      end
      ClassAddSub: begin
        d.dest_reg       = word_i[4:0];
        d.first_src_reg  = word_i[9:5];
        d.second_operand = word_i[20:16];
        d.is_wide        = wide;
        if (!word_i[21]) begin
          d.instruction = IdAddSubSh + {4'b0000, word_i[30:29]};
          d.shift_kind  = word_i[23:22];
          d.shift_count = word_i[15:10];
          if (word_i[23:22] == 2'd3 || (!wide && word_i[15])) st = STATUS_UNALLOC;
        end else begin
          d.instruction = IdAddSubExt + {4'b0000, word_i[30:29]};
          d.extend_kind = word_i[15:13];
          d.shift_count = {3'b000, word_i[12:10]};
          if (word_i[12:10] > 3'd4) st = STATUS_UNALLOC;
        end
      end
      ClassMisc: begin
        if (grp == GrpCarry) begin
          if (opc != 6'd0) begin
            st = STATUS_UNSUP;
          end else begin
            d.dest_reg       = word_i[4:0];
            d.first_src_reg  = word_i[9:5];
            d.second_operand = word_i[20:16];
            d.is_wide        = wide;
            d.instruction    = IdCarry + {4'b0000, word_i[30:29]};
          end
        end else if (grp == GrpCondCmp) begin
          if (!word_i[29] || word_i[10] || word_i[4]) begin
            st = STATUS_UNSUP;
          end else begin
            d.first_src_reg  = word_i[9:5];
            d.second_operand = word_i[20:16];
            d.is_wide        = wide;
            d.cond_code      = word_i[15:12];
            d.flags_value    = word_i[3:0];
            d.instruction    = IdCcmpImm + {4'b0000, !word_i[11], !word_i[30]};
          end
        end else if (grp == GrpCondSel) begin
          if (word_i[29]) begin
            st = STATUS_UNSUP;
          end else if (word_i[11]) begin
            st = STATUS_UNALLOC;
          end else begin
            d.dest_reg       = word_i[4:0];
            d.first_src_reg  = word_i[9:5];
            d.second_operand = word_i[20:16];
            d.is_wide        = wide;
            d.cond_code      = word_i[15:12];
            d.instruction    = IdCondSel + {4'b0000, word_i[30], word_i[10]};
          end
        end else if (grp == GrpSrc && !word_i[29] && !word_i[30]) begin
          d.dest_reg       = word_i[4:0];
          d.first_src_reg  = word_i[9:5];
          d.second_operand = word_i[20:16];
          d.is_wide        = wide;
          if (opc == OpcUdiv || opc == OpcSdiv) begin
            d.instruction = IdDiv + (opc - OpcUdiv);
          end else if (opc >= OpcLslv && opc <= OpcRorv) begin
            d.instruction = IdShiftV + (opc - OpcLslv);
          end else if (opc >= OpcCrc32b && opc <= OpcUmin) begin
            d.instruction = IdCrc + (opc - OpcCrc32b);
            if (opc <= OpcCrc32cx && (wide != (opc[1:0] == 2'd3))) st = STATUS_UNALLOC;
          end else begin
            st = STATUS_UNSUP;
          end
        end else if (grp == GrpSrc && !word_i[29]) begin
          if (word_i[20:16] != 5'd0 || opc > OpcAbs) begin
            st = STATUS_UNSUP;
          end else begin
            d.dest_reg      = word_i[4:0];
            d.first_src_reg = word_i[9:5];
            d.is_wide       = wide;
            d.instruction   = IdOneSrc + opc;
            if (opc == OpcRev64 && !wide) st = STATUS_UNALLOC;
          end
        end else begin
          st = STATUS_UNSUP;
        end
      end
      ClassMul: begin
        d.dest_reg       = word_i[4:0];
        d.first_src_reg  = word_i[9:5];
        d.second_operand = word_i[20:16];
        d.is_wide        = wide;
        if (word_i[30:29] != 2'd0) begin
          st = STATUS_UNSUP;
        end else begin
          unique case (grp)
            MulOpMadd: begin
              d.instruction = word_i[15] ? IdMsub : IdMadd;
              d.addend_reg  = word_i[14:10];
            end
            MulOpSLong, MulOpULong: begin
              if (!wide) st = STATUS_UNALLOC;
              d.instruction = (grp == MulOpSLong ? IdSmsubl : IdUmsubl) + {5'd0, !word_i[15]};
              d.addend_reg  = word_i[14:10];
            end
            MulOpSHigh, MulOpUHigh: begin
              if (!wide || word_i[15] || word_i[14:10] != 5'd31) st = STATUS_UNALLOC;
              d.instruction = (grp == MulOpSHigh) ? IdSmulh : IdUmulh;
            end
            MulOpRsvd: st = wide ? STATUS_UNSUP : STATUS_UNALLOC;
            default: st = STATUS_UNALLOC;
          endcase
        end
      end
      default: st = STATUS_UNSUP;
    endcase
    if (st != STATUS_OK) d = '0;
    d.status = st;
  end

  assign result_o = d;

endmodule

/* design/data_processing_register_decode_core.sv */
// Channel | Handshake             | Payload
// in      | in_valid_i/in_ready_o | instr_word_i (32)
// out     | out_valid_o/out_ready_i | status_o .. flags_value_o
//
// An accepted word is held in the input register, decoded, and its result is held in the output register.
// One word per cycle sustained while the output is not stalled: input register, decode logic, output register.
// A stalled output holds its result; an empty input register still takes a
// word while the output register is full, then stalls until the output drains.
// Reset clears both valid flags; payload registers are not reset.
module data_processing_register_decode_core import dprd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [InstrWidth-1:0] instr_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [5:0]            instruction_o,
  output logic [4:0]            dest_reg_o,
  output logic [4:0]            first_src_reg_o,
  output logic [4:0]            second_operand_o,
  output logic [4:0]            addend_reg_o,
  output logic                  is_wide_o,
  output logic [1:0]            shift_kind_o,
  output logic [5:0]            shift_count_o,
  output logic [2:0]            extend_kind_o,
  output logic [3:0]            cond_code_o,
  output logic [3:0]            flags_value_o
);

  logic                  word_valid_q;
  logic [InstrWidth-1:0] word_q;
  logic                  res_valid_q;
  dec_result_t           res_d, res_q;
  logic                  adv;

  assign adv        = !res_valid_q || out_ready_i;
  assign in_ready_o = !word_valid_q || adv;

  dprd_decode u_decode (
    .word_i   (word_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) word_valid_q <= in_valid_i;
      if (adv) res_valid_q <= word_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) word_q <= instr_word_i;
    if (adv && word_valid_q) res_q <= res_d;
  end

  assign out_valid_o      = res_valid_q;
  assign status_o         = res_q.status;
  assign instruction_o    = res_q.instruction;
  assign dest_reg_o       = res_q.dest_reg;
  assign first_src_reg_o  = res_q.first_src_reg;
  assign second_operand_o = res_q.second_operand;
  assign addend_reg_o     = res_q.addend_reg;
  assign is_wide_o        = res_q.is_wide;
  assign shift_kind_o     = res_q.shift_kind;
  assign shift_count_o    = res_q.shift_count;
  assign extend_kind_o    = res_q.extend_kind;
  assign cond_code_o      = res_q.cond_code;
  assign flags_value_o    = res_q.flags_value;

endmodule
